>>> hw/rtl/thermostat_display_controller_macros.svh
// Assertion macros used by the checker file of the display controller.
`ifndef THERMOSTAT_DISPLAY_CONTROLLER_MACROS_SVH
`define THERMOSTAT_DISPLAY_CONTROLLER_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define TDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that also covers the reset cycles themselves.
`define TDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tdc_pkg.sv
package tdc_pkg;

  // Input opcodes.
  localparam logic [1:0] OPC_TICK   = 2'd0;
  localparam logic [1:0] OPC_SAMPLE = 2'd1;
  localparam logic [1:0] OPC_CMD    = 2'd2;

  // Command bytes (ASCII digits).
  localparam logic [7:0] CMD_UP     = 8'h31;
  localparam logic [7:0] CMD_DOWN   = 8'h32;
  localparam logic [7:0] CMD_TOGGLE = 8'h33;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SP_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SP_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SEC = 3'd4;

  // Scaling thresholds.
  localparam logic [9:0] ADC_LOW_LIMIT  = 10'd104;
  localparam logic [9:0] ADC_HIGH_LIMIT = 10'd305;
  localparam logic [9:0] ADC_OFFSET     = 10'd103;
  localparam logic [6:0] TEMP_MAX       = 7'd99;

  // Multiplex counter values that select each digit.
  localparam logic [7:0] MUX_TENS_AT = 8'd1;
  localparam logic [7:0] MUX_ONES_AT = 8'd15;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_TICK   = 3'd1,
    OP_SAMPLE = 3'd2,
    OP_UP     = 3'd3,
    OP_DOWN   = 3'd4,
    OP_TOGGLE = 3'd5
  } op_kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] adc_value;
    logic [7:0] command_byte;
  } in_t;

  typedef struct packed {
    logic [3:0] digit_code;
    logic       tens_digit_off;
    logic       ones_digit_off;
    logic       led_low;
    logic       led_med;
    logic       led_high;
    logic       view_led;
    logic       beep;
    logic [6:0] temperature;
    logic [6:0] setpoint;
  } out_t;

  // Classified work item passed from front to back.
  typedef struct packed {
    op_kind_t   kind;
    logic [6:0] temp;
    logic [3:0] temp_tens;
    logic [3:0] temp_ones;
  } work_t;

endpackage

>>> hw/rtl/tdc_front.sv
module tdc_front (
  input  tdc_pkg::in_t   in_data,
  output tdc_pkg::work_t work
);

  logic [9:0]  adc_diff;
  logic [9:0]  adc_half;
  logic [6:0]  temp;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;

  // Scale the reading to whole degrees, saturated to the display range.
  always_comb begin
    adc_diff = in_data.adc_value - tdc_pkg::ADC_OFFSET;
    adc_half = adc_diff >> 1;
    if (in_data.adc_value < tdc_pkg::ADC_LOW_LIMIT) begin
      temp = 7'd0;
    end else if (in_data.adc_value >= tdc_pkg::ADC_HIGH_LIMIT) begin
      temp = tdc_pkg::TEMP_MAX;
    end else if (adc_half > 10'(tdc_pkg::TEMP_MAX)) begin
      temp = tdc_pkg::TEMP_MAX;
    end else begin
      temp = adc_half[6:0];
    end
  end

  // Split into decimal digits: divide by ten through the reciprocal 205/2048.
  assign tens_prod = 15'(temp) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = 7'(tens) * 7'd10;

  // Classify the transaction for the back end.
  always_comb begin
    work.temp      = temp;
    work.temp_tens = tens;
    work.temp_ones = 4'(temp - tens_x10);
    unique case (in_data.opcode)
      tdc_pkg::OPC_TICK:   work.kind = tdc_pkg::OP_TICK;
      tdc_pkg::OPC_SAMPLE: work.kind = tdc_pkg::OP_SAMPLE;
      tdc_pkg::OPC_CMD: begin
        if (in_data.command_byte == tdc_pkg::CMD_UP) begin
          work.kind = tdc_pkg::OP_UP;
        end else if (in_data.command_byte == tdc_pkg::CMD_DOWN) begin
          work.kind = tdc_pkg::OP_DOWN;
        end else if (in_data.command_byte == tdc_pkg::CMD_TOGGLE) begin
          work.kind = tdc_pkg::OP_TOGGLE;
        end else begin
          work.kind = tdc_pkg::OP_NONE;
        end
      end
      default: work.kind = tdc_pkg::OP_NONE;
    endcase
  end

endmodule

>>> hw/rtl/tdc_queue.sv
module tdc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tdc_pkg::work_t push_data,
  input  logic           pop,
  output tdc_pkg::work_t head,
  output logic           empty,
  output logic           full
);

  tdc_pkg::work_t                 mem_r [tdc_pkg::QDEPTH];
  logic [tdc_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [tdc_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [tdc_pkg::QCNT_W-1:0]     count_r;
  logic                           do_push;
  logic                           do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == tdc_pkg::QCNT_W'(tdc_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == tdc_pkg::QPTR_W'(tdc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == tdc_pkg::QPTR_W'(tdc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/tdc_back.sv
module tdc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  tdc_pkg::work_t                    head,
  input  logic                              empty,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tdc_pkg::out_t                     out_data
);

  // Configuration registers.
  logic [6:0] sp_min_r;
  logic [6:0] sp_max_r;
  logic [7:0] refresh_r;
  logic [9:0] tps_r;
  logic [1:0] hold_sec_r;

  // Controller state.
  logic [6:0] sp_r, sp_nxt;
  logic [3:0] sp_tens_r, sp_tens_nxt;
  logic [3:0] sp_ones_r, sp_ones_nxt;
  logic [6:0] temp_r, temp_nxt;
  logic [3:0] temp_tens_r, temp_tens_nxt;
  logic [3:0] temp_ones_r, temp_ones_nxt;
  logic [9:0] ms_r, ms_nxt;
  logic [7:0] mux_r, mux_nxt;
  logic [1:0] sec_r, sec_nxt;
  logic       adjust_r, adjust_nxt;
  logic       view_r, view_nxt;

  // Display pins.
  logic [3:0] digit_r, digit_nxt;
  logic       tens_off_r, tens_off_nxt;
  logic       ones_off_r, ones_off_nxt;
  logic       led_low_r, led_low_nxt;
  logic       led_med_r, led_med_nxt;
  logic       led_high_r, led_high_nxt;
  logic       view_led_r, view_led_nxt;
  logic       beep;

  logic          out_valid_r;
  tdc_pkg::out_t out_r;

  logic [9:0] ms_inc;
  logic [7:0] mux_inc;
  logic [1:0] sec_inc;
  logic [7:0] sp_plus2;
  logic [7:0] sp_plus4;
  logic [7:0] temp_ext;

  // The head transaction executes when the queue is not empty and the output register is free or being drained.
  assign pop       = !empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ms_inc   = ms_r + 10'd1;
  assign mux_inc  = mux_r + 8'd1;
  assign sec_inc  = sec_r + 2'd1;
  assign sp_plus2 = {1'b0, sp_r} + 8'd2;
  assign sp_plus4 = {1'b0, sp_r} + 8'd4;
  assign temp_ext = {1'b0, head.temp};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_min_r   <= 7'd5;
      sp_max_r   <= 7'd90;
      refresh_r  <= 8'd29;
      tps_r      <= 10'd1000;
      hold_sec_r <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        tdc_pkg::CFG_SP_MIN:   sp_min_r   <= cfg_data[6:0];
        tdc_pkg::CFG_SP_MAX:   sp_max_r   <= cfg_data[6:0];
        tdc_pkg::CFG_REFRESH:  refresh_r  <= cfg_data[7:0];
        tdc_pkg::CFG_TPS:      tps_r      <= cfg_data[9:0];
        tdc_pkg::CFG_HOLD_SEC: hold_sec_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Execute the transaction at the queue head.
  always_comb begin
    sp_nxt        = sp_r;
    sp_tens_nxt   = sp_tens_r;
    sp_ones_nxt   = sp_ones_r;
    temp_nxt      = temp_r;
    temp_tens_nxt = temp_tens_r;
    temp_ones_nxt = temp_ones_r;
    ms_nxt        = ms_r;
    mux_nxt       = mux_r;
    sec_nxt       = sec_r;
    adjust_nxt    = adjust_r;
    view_nxt      = view_r;
    digit_nxt     = digit_r;
    tens_off_nxt  = tens_off_r;
    ones_off_nxt  = ones_off_r;
    led_low_nxt   = led_low_r;
    led_med_nxt   = led_med_r;
    led_high_nxt  = led_high_r;
    view_led_nxt  = view_led_r;
    beep          = 1'b0;
    unique case (head.kind)
      tdc_pkg::OP_TICK: begin
        // Digit multiplexing.
        ms_nxt  = ms_inc;
        mux_nxt = mux_inc;
        if (mux_inc == tdc_pkg::MUX_TENS_AT) begin
          ones_off_nxt = 1'b1;
          tens_off_nxt = 1'b0;
          digit_nxt    = view_r ? sp_tens_r : temp_tens_r;
        end else if (mux_inc == tdc_pkg::MUX_ONES_AT) begin
          tens_off_nxt = 1'b1;
          ones_off_nxt = 1'b0;
          digit_nxt    = view_r ? sp_ones_r : temp_ones_r;
        end else if (mux_inc == refresh_r) begin
          mux_nxt = 8'd0;
        end
        // Setpoint view timeout, counted in whole seconds.
        if (ms_inc == tps_r) begin
          ms_nxt = 10'd0;
          if (adjust_r) begin
            sec_nxt = sec_inc;
            if (sec_inc == hold_sec_r) begin
              view_led_nxt = 1'b0;
              view_nxt     = 1'b0;
              adjust_nxt   = 1'b0;
              sec_nxt      = 2'd0;
            end
          end
        end
      end
      tdc_pkg::OP_SAMPLE: begin
        // The highest offset reached decides the level pattern.
        temp_nxt      = head.temp;
        temp_tens_nxt = head.temp_tens;
        temp_ones_nxt = head.temp_ones;
        if (temp_ext >= sp_plus4) begin
          led_low_nxt  = 1'b1;
          led_med_nxt  = 1'b1;
          led_high_nxt = 1'b0;
        end else if (temp_ext >= sp_plus2) begin
          led_low_nxt  = 1'b1;
          led_med_nxt  = 1'b0;
          led_high_nxt = 1'b1;
        end else if (head.temp >= sp_r) begin
          led_low_nxt  = 1'b0;
          led_med_nxt  = 1'b1;
          led_high_nxt = 1'b1;
        end
      end
      tdc_pkg::OP_UP: begin
        beep       = 1'b1;
        adjust_nxt = 1'b1;
        view_nxt   = 1'b1;
        if (sp_r < sp_max_r && sp_r < tdc_pkg::TEMP_MAX) begin
          sp_nxt = sp_r + 7'd1;
          if (sp_ones_r >= 4'd9) begin
            sp_tens_nxt = sp_tens_r + 4'd1;
            sp_ones_nxt = 4'd0;
          end else begin
            sp_ones_nxt = sp_ones_r + 4'd1;
          end
        end
      end
      tdc_pkg::OP_DOWN: begin
        beep       = 1'b1;
        adjust_nxt = 1'b1;
        view_nxt   = 1'b1;
        if (sp_r > sp_min_r) begin
          sp_nxt = sp_r - 7'd1;
          if (sp_ones_r == 4'd0) begin
            sp_tens_nxt = sp_tens_r - 4'd1;
            sp_ones_nxt = 4'd9;
          end else begin
            sp_ones_nxt = sp_ones_r - 4'd1;
          end
        end
      end
      tdc_pkg::OP_TOGGLE: begin
        view_nxt     = !view_r;
        view_led_nxt = !view_led_r;
      end
      default: ;
    endcase
  end

  // State update on each executed transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= 7'd25;
      sp_tens_r   <= 4'd2;
      sp_ones_r   <= 4'd5;
      temp_r      <= 7'd0;
      temp_tens_r <= 4'd0;
      temp_ones_r <= 4'd0;
      ms_r        <= 10'd0;
      mux_r       <= 8'd0;
      sec_r       <= 2'd0;
      adjust_r    <= 1'b0;
      view_r      <= 1'b0;
      digit_r     <= 4'd0;
      tens_off_r  <= 1'b1;
      ones_off_r  <= 1'b1;
      led_low_r   <= 1'b1;
      led_med_r   <= 1'b1;
      led_high_r  <= 1'b1;
      view_led_r  <= 1'b0;
    end else if (pop) begin
      sp_r        <= sp_nxt;
      sp_tens_r   <= sp_tens_nxt;
      sp_ones_r   <= sp_ones_nxt;
      temp_r      <= temp_nxt;
      temp_tens_r <= temp_tens_nxt;
      temp_ones_r <= temp_ones_nxt;
      ms_r        <= ms_nxt;
      mux_r       <= mux_nxt;
      sec_r       <= sec_nxt;
      adjust_r    <= adjust_nxt;
      view_r      <= view_nxt;
      digit_r     <= digit_nxt;
      tens_off_r  <= tens_off_nxt;
      ones_off_r  <= ones_off_nxt;
      led_low_r   <= led_low_nxt;
      led_med_r   <= led_med_nxt;
      led_high_r  <= led_high_nxt;
      view_led_r  <= view_led_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload shows the state after the transaction.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_r.digit_code     <= digit_nxt;
      out_r.tens_digit_off <= tens_off_nxt;
      out_r.ones_digit_off <= ones_off_nxt;
      out_r.led_low        <= led_low_nxt;
      out_r.led_med        <= led_med_nxt;
      out_r.led_high       <= led_high_nxt;
      out_r.view_led       <= view_led_nxt;
      out_r.beep           <= beep;
      out_r.temperature    <= temp_nxt;
      out_r.setpoint       <= sp_nxt;
    end
  end

endmodule

>>> hw/rtl/thermostat_display_controller.sv
// Thermostat display controller. Ticks, ADC samples and command bytes enter
// on the in_ channel; each one yields exactly one result on the out_ channel
// showing the display pins, beep, temperature and setpoint after that item.
// The block takes one item per clock cycle while in_stall is low: a front
// end classifies the item and scales the reading, a two-entry queue holds
// it, and a back end executes one item per cycle into an output register
// unless out_stall holds a valid result. in_stall rises only when the queue
// is full. Configuration writes are always taken (cfg_ready is held high)
// and must be issued while idle.
module thermostat_display_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tdc_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tdc_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tdc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tdc_pkg::work_t work;
  tdc_pkg::work_t head;
  logic           q_empty;
  logic           q_full;
  logic           pop;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  tdc_front u_front (
    .in_data (in_data),
    .work    (work)
  );

  tdc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (work),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/tdc_checker.sv
`include "thermostat_display_controller_macros.svh"

module tdc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input tdc_pkg::out_t                     out_data
);

  // A stalled result stays valid and unchanged.
  `TDC_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_data),
    "result changed while stalled")

  // The two digit selects are never driven on at the same time.
  `TDC_ASSERT(a_one_digit,
    out_valid |-> (out_data.tens_digit_off || out_data.ones_digit_off),
    "both digits enabled")

  // Shown digit and degree values stay in decimal display range.
  `TDC_ASSERT(a_range,
    out_valid |-> (out_data.digit_code <= 4'd9 && out_data.temperature <= 7'd99
                   && out_data.setpoint <= 7'd99),
    "display value out of range")

  // No result is presented in the cycle after reset.
  `TDC_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind thermostat_display_controller tdc_checker u_tdc_checker (.*);

>>> dv/tb_thermostat_display_controller.sv
module tb_thermostat_display_controller;
  import tdc_pkg::*;

  // Opcode value that the block has no use for.
  localparam logic [1:0] OPC_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  thermostat_display_controller dut (.*);

  always #6 clk = ~clk;

  // Items waiting for the driver and display readouts waiting for the monitor.
  in_t         pending_items[$];
  out_t        expected_readouts[$];
  out_t        oldest_readout;
  int unsigned readouts_owed  = 0;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Register copies.
  logic [6:0] lim_min, lim_max;
  logic [7:0] refresh_at;
  logic [9:0] ticks_per_sec;
  logic [1:0] hold_secs;

  // Controller state as the predictor sees it.
  logic [6:0] sp_value, temp_value;
  logic [3:0] sp_tens, sp_ones, temp_tens, temp_ones;
  logic [9:0] ms_count;
  logic [7:0] mux_count;
  logic [1:0] sec_count;
  logic       adjusting, showing_setpoint;
  logic [3:0] pin_digit;
  logic       pin_tens_off, pin_ones_off, pin_low, pin_med, pin_high, pin_view;

  function automatic void reset_model();
    lim_min          = 7'd5;
    lim_max          = 7'd90;
    refresh_at       = 8'd29;
    ticks_per_sec    = 10'd1000;
    hold_secs        = 2'd2;
    sp_value         = 7'd25;
    sp_tens          = 4'd2;
    sp_ones          = 4'd5;
    temp_value       = '0;
    temp_tens        = '0;
    temp_ones        = '0;
    ms_count         = '0;
    mux_count        = '0;
    sec_count        = '0;
    adjusting        = 1'b0;
    showing_setpoint = 1'b0;
    pin_digit        = '0;
    pin_tens_off     = 1'b1;
    pin_ones_off     = 1'b1;
    pin_low          = 1'b1;
    pin_med          = 1'b1;
    pin_high         = 1'b1;
    pin_view         = 1'b0;
  endfunction

  // Advance the controller by one item and return the pins it leaves behind.
  function automatic out_t display_after(input in_t item);
    int unsigned t;
    int unsigned sp;
    logic        chirp;
    out_t        r;
    chirp = 1'b0;
    sp = 32'(sp_value);
    case (item.opcode)
      OPC_TICK: begin
        ms_count++;
        mux_count++;
        if (mux_count == MUX_TENS_AT) begin
          pin_ones_off = 1'b1;
          pin_digit    = showing_setpoint ? sp_tens : temp_tens;
          pin_tens_off = 1'b0;
        end else if (mux_count == MUX_ONES_AT) begin
          pin_tens_off = 1'b1;
          pin_digit    = showing_setpoint ? sp_ones : temp_ones;
          pin_ones_off = 1'b0;
        end else if (mux_count == refresh_at) begin
          mux_count = '0;
        end
        // One second has passed; the view times out after the hold time.
        if (ms_count == ticks_per_sec) begin
          ms_count = '0;
          if (adjusting) begin
            sec_count++;
            if (sec_count == hold_secs) begin
              pin_view         = 1'b0;
              showing_setpoint = 1'b0;
              adjusting        = 1'b0;
              sec_count        = '0;
            end
          end
        end
      end
      OPC_SAMPLE: begin
        if (item.adc_value < ADC_LOW_LIMIT) t = 0;
        else if (item.adc_value >= ADC_HIGH_LIMIT) t = 32'(TEMP_MAX);
        else t = (32'(item.adc_value) - 32'(ADC_OFFSET)) / 2;
        if (t > 32'(TEMP_MAX)) t = 32'(TEMP_MAX);
        // Later offsets override earlier ones; below the setpoint nothing moves.
        if (t >= sp) begin
          pin_high = 1'b1; pin_med = 1'b1; pin_low = 1'b0;
        end
        if (t >= sp + 2) begin
          pin_high = 1'b1; pin_low = 1'b1; pin_med = 1'b0;
        end
        if (t >= sp + 4) begin
          pin_med = 1'b1; pin_low = 1'b1; pin_high = 1'b0;
        end
        temp_value = 7'(t);
        temp_tens  = 4'(t / 10);
        temp_ones  = 4'(t % 10);
      end
      OPC_CMD: begin
        if (item.command_byte == CMD_UP || item.command_byte == CMD_DOWN) begin
          chirp            = 1'b1;
          adjusting        = 1'b1;
          showing_setpoint = 1'b1;
          if (item.command_byte == CMD_UP) begin
            if (sp_value < lim_max && sp_value < TEMP_MAX) begin
              sp_value++;
              if (sp_ones == 4'd9) begin
                sp_tens++;
                sp_ones = '0;
              end else begin
                sp_ones++;
              end
            end
          end else if (sp_value > lim_min) begin
            sp_value--;
            if (sp_ones == 4'd0) begin
              sp_tens--;
              sp_ones = 4'd9;
            end else begin
              sp_ones--;
            end
          end
        end else if (item.command_byte == CMD_TOGGLE) begin
          showing_setpoint = !showing_setpoint;
          pin_view         = !pin_view;
        end
      end
      default: ;
    endcase
    r.digit_code     = pin_digit;
    r.tens_digit_off = pin_tens_off;
    r.ones_digit_off = pin_ones_off;
    r.led_low        = pin_low;
    r.led_med        = pin_med;
    r.led_high       = pin_high;
    r.view_led       = pin_view;
    r.beep           = chirp;
    r.temperature    = temp_value;
    r.setpoint       = sp_value;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Driver: presents queued items and predicts each transaction it completes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_readouts.push_back(display_after(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readouts.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %p",
                   $time, out_data);
          mismatches++;
        end else begin
          oldest_readout = expected_readouts.pop_front();
          readouts_owed--;
          check_field("digit_code", 32'(oldest_readout.digit_code),
                      32'(out_data.digit_code));
          check_field("tens_digit_off", 32'(oldest_readout.tens_digit_off),
                      32'(out_data.tens_digit_off));
          check_field("ones_digit_off", 32'(oldest_readout.ones_digit_off),
                      32'(out_data.ones_digit_off));
          check_field("led_low", 32'(oldest_readout.led_low), 32'(out_data.led_low));
          check_field("led_med", 32'(oldest_readout.led_med), 32'(out_data.led_med));
          check_field("led_high", 32'(oldest_readout.led_high), 32'(out_data.led_high));
          check_field("view_led", 32'(oldest_readout.view_led), 32'(out_data.view_led));
          check_field("beep", 32'(oldest_readout.beep), 32'(out_data.beep));
          check_field("temperature", 32'(oldest_readout.temperature),
                      32'(out_data.temperature));
          check_field("setpoint", 32'(oldest_readout.setpoint), 32'(out_data.setpoint));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic [9:0] adc,
                            input logic [7:0] cmd);
    in_t item;
    item.opcode       = op;
    item.adc_value    = adc;
    item.command_byte = cmd;
    readouts_owed++;
    pending_items.push_back(item);
  endtask

  // Random traffic built from tick runs, sample groups and adjust bursts,
  // with some unknown bytes and unused opcodes mixed in.
  task automatic push_random(input int n);
    int         made;
    int         pick;
    int         len;
    logic [7:0] dir;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(1, 24);
        repeat (len) queue_item(OPC_TICK, 10'($urandom), 8'($urandom));
        made += len;
      end else if (pick < 65) begin
        len = $urandom_range(1, 4);
        repeat (len)
          queue_item(OPC_SAMPLE,
                     10'($urandom_range(1) ? $urandom_range(100, 320) : $urandom_range(1023)),
                     8'($urandom));
        made += len;
      end else if (pick < 92) begin
        len = $urandom_range(1, 12);
        dir = $urandom_range(1) ? CMD_UP : CMD_DOWN;
        repeat (len)
          queue_item(OPC_CMD, 10'($urandom), ($urandom_range(4) == 0) ? CMD_TOGGLE : dir);
        made += len;
      end else begin
        queue_item($urandom_range(1) ? OPC_UNUSED : OPC_CMD, 10'($urandom), 8'($urandom));
      end
    end
  endtask

  // Write every register in turn; only called while nothing is in flight.
  task automatic set_registers(input int unsigned vmin, input int unsigned vmax,
                               input int unsigned vrefresh, input int unsigned vtps,
                               input int unsigned vhold);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] val[5];
    idx = '{CFG_SP_MIN, CFG_SP_MAX, CFG_REFRESH, CFG_TPS, CFG_HOLD_SEC};
    val = '{CFG_DATA_W'(vmin), CFG_DATA_W'(vmax), CFG_DATA_W'(vrefresh),
            CFG_DATA_W'(vtps), CFG_DATA_W'(vhold)};
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_SP_MIN:  lim_min       = val[i][6:0];
        CFG_SP_MAX:  lim_max       = val[i][6:0];
        CFG_REFRESH: refresh_at    = val[i][7:0];
        CFG_TPS:     ticks_per_sec = val[i][9:0];
        default:     hold_secs     = val[i][1:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait for every outstanding result, then let the pipeline settle.
  task automatic drain();
    while (readouts_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned vmin, input int unsigned vmax,
                           input int unsigned vrefresh, input int unsigned vtps,
                           input int unsigned vhold, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int n);
    set_registers(vmin, vmax, vrefresh, vtps, vhold);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    push_random(n);
    drain();
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scaling edges, level offsets around the setpoint of 25, and a few ticks.
    queue_item(OPC_SAMPLE, 10'd0, 8'h00);
    queue_item(OPC_SAMPLE, 10'd103, 8'hFF);
    queue_item(OPC_SAMPLE, 10'd104, 8'h00);
    queue_item(OPC_SAMPLE, 10'd105, 8'hFF);
    queue_item(OPC_SAMPLE, 10'd153, 8'h00);
    queue_item(OPC_SAMPLE, 10'd157, 8'h00);
    queue_item(OPC_SAMPLE, 10'd161, 8'h00);
    queue_item(OPC_SAMPLE, 10'd303, 8'h00);
    queue_item(OPC_SAMPLE, 10'd304, 8'h00);
    queue_item(OPC_SAMPLE, 10'd305, 8'h00);
    queue_item(OPC_SAMPLE, 10'd1023, 8'hFF);
    queue_item(OPC_TICK, 10'h3FF, 8'hFF);
    queue_item(OPC_TICK, 10'h000, 8'h00);
    // Every command, ignored bytes around the command range, and the unused opcode.
    queue_item(OPC_CMD, 10'h000, CMD_UP);
    queue_item(OPC_CMD, 10'h3FF, CMD_DOWN);
    queue_item(OPC_CMD, 10'h000, CMD_TOGGLE);
    queue_item(OPC_CMD, 10'h000, CMD_TOGGLE);
    queue_item(OPC_CMD, 10'h000, 8'h00);
    queue_item(OPC_CMD, 10'h000, 8'hFF);
    queue_item(OPC_CMD, 10'h000, 8'h30);
    queue_item(OPC_CMD, 10'h000, 8'h34);
    queue_item(OPC_UNUSED, 10'h3FF, CMD_UP);
    queue_item(OPC_TICK, 10'h155, 8'hAA);
    queue_item(OPC_TICK, 10'h2AA, 8'h55);
    push_random(200);
    drain();

    run_phase(0, 99, 16, 1, 1, 74, 0, 250);
    run_phase(99, 0, 255, 1023, 3, 0, 74, 200);
    run_phase(20, 30, 29, 7, 2, 17, 17, 300);
    run_phase(5, 90, 40, 13, 3, 0, 0, 250);
    run_phase(0, 99, 16, 3, 1, 74, 0, 250);
    run_phase(45, 55, 100, 2, 2, 0, 74, 200);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(12 * 300000);
    $display("FAILURE");
    $finish;
  end

endmodule
